// ===== hdl/tricirc_pkg.sv =====
// Shared widths, constants and transaction types for the triangle circumcircle core.
// No dependencies; every other file in hdl/ refers to it by scoped names.
`default_nettype none
package tricirc_pkg;

	// coordinate width and the widths that follow from it
	localparam int CB  = 16;
	localparam int AW  = 2*CB + 2;     // twice the signed area
	localparam int DW  = 2*CB + 2;     // determinant D, unsigned
	localparam int SQW = 2*CB;         // x*x + y*y, unsigned
	localparam int DFW = CB + 1;       // coordinate difference, signed
	localparam int PW  = SQW + 1 + DFW; // square times difference, signed
	localparam int NW  = PW + 2;       // center numerator, signed
	localparam int KW  = NW + 10;      // numerator times 1000, signed
	localparam int NMW = KW - 1;       // its magnitude, also quotient bits

	localparam int MW  = CB + 10;      // coordinate times 1000, signed
	localparam int OW  = 48;           // result width
	localparam int HW  = OW / 2;       // half word for the squaring
	localparam int RB  = OW + 1;       // root bits

	// pipeline depth: front end, divider, radius path
	localparam int LATENCY = 6 + (NMW + 3) + (RB + 6);

	localparam logic [OW-1:0] POS_MAX = {1'b0, {(OW-1){1'b1}}};

	typedef logic signed [CB-1:0] coord_t;
	typedef logic signed [OW-1:0] milli_t;

	// per-transaction data that rides along the whole pipeline
	typedef struct packed {
		coord_t second_x;
		coord_t second_y;
		coord_t third_x;
		coord_t third_y;
		logic swapped;
		logic degen;
		logic signed [MW-1:0] axm;
		logic signed [MW-1:0] aym;
	} meta_t;

	typedef struct packed {
		meta_t meta;
		logic [DW-1:0] d;
		logic signed [KW-1:0] kx;
		logic signed [KW-1:0] ky;
	} front_t;

	typedef struct packed {
		meta_t meta;
		milli_t cxm;
		milli_t cym;
		logic covf;
	} cen_t;

	typedef struct packed {
		meta_t meta;
		milli_t cxm;
		milli_t cym;
		logic [OW-1:0] rad;
		logic ovf;
	} res_t;

endpackage
`default_nettype wire

// ===== hdl/tricirc_front.sv =====
// Front end: orientation, determinant and scaled circumcenter numerators in six stages.
// Depends on tricirc_pkg.
`default_nettype none
module tricirc_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire tricirc_pkg::coord_t ax, ay, bx, by, cx, cy,
	output logic out_valid,
	output tricirc_pkg::front_t out_data
);
	localparam int CB  = tricirc_pkg::CB;
	localparam int AW  = tricirc_pkg::AW;
	localparam int DW  = tricirc_pkg::DW;
	localparam int SQW = tricirc_pkg::SQW;
	localparam int DFW = tricirc_pkg::DFW;
	localparam int PW  = tricirc_pkg::PW;
	localparam int NW  = tricirc_pkg::NW;
	localparam int KW  = tricirc_pkg::KW;
	localparam int MW  = tricirc_pkg::MW;

	// times 1000 as 1024 - 16 - 8
	function automatic logic signed [KW-1:0] by_milli(logic signed [KW-1:0] v);
		return (v <<< 10) - (v <<< 4) - (v <<< 3);
	endfunction

	logic [6:1] v_s;

	tricirc_pkg::coord_t ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [2*CB-1:0] p_s1 [6];

	tricirc_pkg::coord_t ax_s2, ay_s2, bx_s2, by_s2, cx_s2, cy_s2;
	logic signed [AW-1:0] area_s2;
	logic [SQW-1:0] sa_s2, sb_s2, sc_s2;

	tricirc_pkg::coord_t ax_s3, ay_s3, bx_s3, by_s3, cx_s3, cy_s3;
	logic swap_s3, degen_s3;
	logic [DW-1:0] d_s3;
	logic [SQW-1:0] sa_s3, sb_s3, sc_s3;
	logic signed [DFW-1:0] dy_s3 [3];
	logic signed [DFW-1:0] dx_s3 [3];

	tricirc_pkg::meta_t meta_s4, meta_s5, meta_s6;
	logic [DW-1:0] d_s4, d_s5, d_s6;
	logic signed [PW-1:0] px_s4 [3];
	logic signed [PW-1:0] py_s4 [3];
	logic signed [NW-1:0] nx_s5, ny_s5;
	logic signed [KW-1:0] kx_s6, ky_s6;

	logic swap_c;
	logic signed [AW-1:0] amag_c;
	tricirc_pkg::coord_t b2x_c, b2y_c, c2x_c, c2y_c;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[5:1], in_valid};
		end
	end

	// stage 1: cross products of the area
	always_ff @(posedge clk) begin
		ax_s1 <= ax;
		ay_s1 <= ay;
		bx_s1 <= bx;
		by_s1 <= by;
		cx_s1 <= cx;
		cy_s1 <= cy;
		p_s1[0] <= ax * by;
		p_s1[1] <= bx * cy;
		p_s1[2] <= cx * ay;
		p_s1[3] <= bx * ay;
		p_s1[4] <= cx * by;
		p_s1[5] <= ax * cy;
	end

	// stage 2: twice the signed area, squared norms
	always_ff @(posedge clk) begin
		ax_s2 <= ax_s1;
		ay_s2 <= ay_s1;
		bx_s2 <= bx_s1;
		by_s2 <= by_s1;
		cx_s2 <= cx_s1;
		cy_s2 <= cy_s1;
		area_s2 <= p_s1[0] + p_s1[1] + p_s1[2] - p_s1[3] - p_s1[4] - p_s1[5];
		sa_s2 <= ax_s1 * ax_s1 + ay_s1 * ay_s1;
		sb_s2 <= bx_s1 * bx_s1 + by_s1 * by_s1;
		sc_s2 <= cx_s1 * cx_s1 + cy_s1 * cy_s1;
	end

	// swap B and C unless the area is positive
	always_comb begin
		swap_c = (area_s2 <= 0);
		amag_c = swap_c ? -area_s2 : area_s2;
		b2x_c = swap_c ? cx_s2 : bx_s2;
		b2y_c = swap_c ? cy_s2 : by_s2;
		c2x_c = swap_c ? bx_s2 : cx_s2;
		c2y_c = swap_c ? by_s2 : cy_s2;
	end

	// stage 3: D, ordered vertices and differences
	always_ff @(posedge clk) begin
		ax_s3 <= ax_s2;
		ay_s3 <= ay_s2;
		bx_s3 <= b2x_c;
		by_s3 <= b2y_c;
		cx_s3 <= c2x_c;
		cy_s3 <= c2y_c;
		swap_s3 <= swap_c;
		degen_s3 <= (area_s2 == 0);
		d_s3 <= {amag_c[DW-2:0], 1'b0};
		sa_s3 <= sa_s2;
		sb_s3 <= swap_c ? sc_s2 : sb_s2;
		sc_s3 <= swap_c ? sb_s2 : sc_s2;
		dy_s3[0] <= b2y_c - c2y_c;
		dy_s3[1] <= c2y_c - ay_s2;
		dy_s3[2] <= ay_s2 - b2y_c;
		dx_s3[0] <= c2x_c - b2x_c;
		dx_s3[1] <= ax_s2 - c2x_c;
		dx_s3[2] <= b2x_c - ax_s2;
	end

	// stage 4: numerator terms, vertex A in thousandths
	always_ff @(posedge clk) begin
		px_s4[0] <= $signed({1'b0, sa_s3}) * dy_s3[0];
		px_s4[1] <= $signed({1'b0, sb_s3}) * dy_s3[1];
		px_s4[2] <= $signed({1'b0, sc_s3}) * dy_s3[2];
		py_s4[0] <= $signed({1'b0, sa_s3}) * dx_s3[0];
		py_s4[1] <= $signed({1'b0, sb_s3}) * dx_s3[1];
		py_s4[2] <= $signed({1'b0, sc_s3}) * dx_s3[2];
		d_s4 <= d_s3;
		meta_s4.second_x <= bx_s3;
		meta_s4.second_y <= by_s3;
		meta_s4.third_x <= cx_s3;
		meta_s4.third_y <= cy_s3;
		meta_s4.swapped <= swap_s3;
		meta_s4.degen <= degen_s3;
		meta_s4.axm <= MW'(by_milli(KW'(ax_s3)));
		meta_s4.aym <= MW'(by_milli(KW'(ay_s3)));
	end

	// stage 5: sum numerators
	always_ff @(posedge clk) begin
		nx_s5 <= px_s4[0] + px_s4[1] + px_s4[2];
		ny_s5 <= py_s4[0] + py_s4[1] + py_s4[2];
		d_s5 <= d_s4;
		meta_s5 <= meta_s4;
	end

	// stage 6: scale numerators to thousandths
	always_ff @(posedge clk) begin
		kx_s6 <= by_milli(KW'(nx_s5));
		ky_s6 <= by_milli(KW'(ny_s5));
		d_s6 <= d_s5;
		meta_s6 <= meta_s5;
	end

	assign out_valid = v_s[6];

	always_comb begin
		out_data.meta = meta_s6;
		out_data.d = d_s6;
		out_data.kx = kx_s6;
		out_data.ky = ky_s6;
	end

endmodule
`default_nettype wire

// ===== hdl/tricirc_div.sv =====
// Pipelined restoring divider for both center coordinates, one quotient bit per stage,
// followed by half-away rounding and 48-bit saturation. Depends on tricirc_pkg.
`default_nettype none
module tricirc_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire tricirc_pkg::front_t in_data,
	output logic out_valid,
	output tricirc_pkg::cen_t out_data
);
	localparam int DW  = tricirc_pkg::DW;
	localparam int KW  = tricirc_pkg::KW;
	localparam int NMW = tricirc_pkg::NMW;
	localparam int OW  = tricirc_pkg::OW;

	typedef struct packed {
		logic neg;
		logic [DW-1:0] rem;
		logic [NMW-1:0] qm;
	} dlane_t;

	// split sign and magnitude; the magnitude shifts out as quotient bits shift in
	function automatic dlane_t load_lane(logic signed [KW-1:0] k);
		dlane_t r;
		logic signed [KW-1:0] m;
		m = k[KW-1] ? -k : k;
		r.neg = k[KW-1];
		r.rem = '0;
		r.qm = m[NMW-1:0];
		return r;
	endfunction

	function automatic dlane_t div_step(dlane_t a, logic [DW-1:0] d);
		dlane_t r;
		logic [DW:0] trial;
		trial = {a.rem, a.qm[NMW-1]};
		r.neg = a.neg;
		if (trial >= {1'b0, d}) begin
			r.rem = DW'(trial - {1'b0, d});
			r.qm = {a.qm[NMW-2:0], 1'b1};
		end else begin
			r.rem = trial[DW-1:0];
			r.qm = {a.qm[NMW-2:0], 1'b0};
		end
		return r;
	endfunction

	// round up when twice the remainder reaches the divisor
	function automatic logic [NMW:0] round_up(dlane_t a, logic [DW-1:0] d);
		logic up;
		up = ({a.rem, 1'b0} >= {1'b0, d});
		return {1'b0, a.qm} + {{NMW{1'b0}}, up};
	endfunction

	// clamp to the signed 48-bit range, overflow flag on top
	function automatic logic [OW:0] saturate(logic neg, logic [NMW:0] q);
		logic [NMW:0] lim;
		logic [OW-1:0] mag;
		logic ovf;
		lim = {{(NMW+1-OW){1'b0}}, tricirc_pkg::POS_MAX} + {{NMW{1'b0}}, neg};
		ovf = (q > lim);
		mag = ovf ? lim[OW-1:0] : q[OW-1:0];
		return {ovf, neg ? -mag : mag};
	endfunction

	logic [NMW+2:0] v_s;
	dlane_t xl_s [0:NMW];
	dlane_t yl_s [0:NMW];
	logic [DW-1:0] d_s [0:NMW];
	tricirc_pkg::meta_t meta_s [0:NMW];

	logic [NMW:0] qx_sr, qy_sr;
	logic negx_sr, negy_sr;
	tricirc_pkg::meta_t meta_sr;

	tricirc_pkg::cen_t cen_ss;

	logic ovfx_c, ovfy_c;
	tricirc_pkg::milli_t cxv_c, cyv_c;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[NMW+1:0], in_valid};
		end
	end

	// load stage
	always_ff @(posedge clk) begin
		xl_s[0] <= load_lane(in_data.kx);
		yl_s[0] <= load_lane(in_data.ky);
		d_s[0] <= in_data.d;
		meta_s[0] <= in_data.meta;
	end

	// one quotient bit per stage
	for (genvar g = 0; g < NMW; g++) begin : g_stage
		always_ff @(posedge clk) begin
			xl_s[g+1] <= div_step(xl_s[g], d_s[g]);
			yl_s[g+1] <= div_step(yl_s[g], d_s[g]);
			d_s[g+1] <= d_s[g];
			meta_s[g+1] <= meta_s[g];
		end
	end

	// round half away from zero
	always_ff @(posedge clk) begin
		qx_sr <= round_up(xl_s[NMW], d_s[NMW]);
		qy_sr <= round_up(yl_s[NMW], d_s[NMW]);
		negx_sr <= xl_s[NMW].neg;
		negy_sr <= yl_s[NMW].neg;
		meta_sr <= meta_s[NMW];
	end

	always_comb begin
		{ovfx_c, cxv_c} = saturate(negx_sr, qx_sr);
		{ovfy_c, cyv_c} = saturate(negy_sr, qy_sr);
	end

	// saturate; drop the center of a collinear transaction
	always_ff @(posedge clk) begin
		cen_ss.meta <= meta_sr;
		cen_ss.cxm <= meta_sr.degen ? '0 : cxv_c;
		cen_ss.cym <= meta_sr.degen ? '0 : cyv_c;
		cen_ss.covf <= !meta_sr.degen && (ovfx_c || ovfy_c);
	end

	assign out_valid = v_s[NMW+2];
	assign out_data = cen_ss;

endmodule
`default_nettype wire

// ===== hdl/tricirc_sqrt.sv =====
// Radius path: distance from vertex A to the rounded center, squared in split products,
// then a pipelined digit-by-digit square root, one root bit per stage. Depends on tricirc_pkg.
`default_nettype none
module tricirc_sqrt (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire tricirc_pkg::cen_t in_data,
	output logic out_valid,
	output tricirc_pkg::res_t out_data
);
	localparam int OW = tricirc_pkg::OW;
	localparam int HW = tricirc_pkg::HW;
	localparam int RB = tricirc_pkg::RB;

	typedef struct packed {
		logic [RB+1:0] rem;
		logic [RB-1:0] root;
	} sq_t;

	function automatic logic [OW-1:0] abs_lo(logic signed [OW:0] v);
		logic signed [OW:0] m;
		m = v[OW] ? -v : v;
		return m[OW-1:0];
	endfunction

	// bring down two radicand bits, try root*4+1
	function automatic sq_t sq_step(sq_t a, logic [1:0] pair);
		sq_t r;
		logic [RB+3:0] t;
		logic [RB+3:0] c;
		t = {a.rem, pair};
		c = {2'b00, a.root, 2'b01};
		if (t >= c) begin
			r.rem = (RB+2)'(t - c);
			r.root = {a.root[RB-2:0], 1'b1};
		end else begin
			r.rem = t[RB+1:0];
			r.root = {a.root[RB-2:0], 1'b0};
		end
		return r;
	endfunction

	logic [RB+5:0] v_s;

	tricirc_pkg::cen_t cen_s1, cen_s2, cen_s3, cen_s4;
	logic signed [OW:0] dx_s1, dy_s1;
	logic [OW-1:0] ux_s2, uy_s2;
	logic [OW-1:0] hhx_s3, hlx_s3, llx_s3, hhy_s3, hly_s3, lly_s3;
	logic [2*OW-1:0] sqx_s4, sqy_s4;

	sq_t sr_s [0:RB];
	logic [2*RB-1:0] dsq_s [0:RB];
	tricirc_pkg::cen_t cr_s [0:RB];

	tricirc_pkg::res_t res_q;
	logic [OW-1:0] rad_c;
	logic ovf_c;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[RB+4:0], in_valid};
		end
	end

	// stage 1: offsets from vertex A
	always_ff @(posedge clk) begin
		dx_s1 <= (OW+1)'(in_data.meta.axm) - (OW+1)'(in_data.cxm);
		dy_s1 <= (OW+1)'(in_data.meta.aym) - (OW+1)'(in_data.cym);
		cen_s1 <= in_data;
	end

	// stage 2: magnitudes
	always_ff @(posedge clk) begin
		ux_s2 <= abs_lo(dx_s1);
		uy_s2 <= abs_lo(dy_s1);
		cen_s2 <= cen_s1;
	end

	// stage 3: half-word partial products
	always_ff @(posedge clk) begin
		hhx_s3 <= ux_s2[OW-1:HW] * ux_s2[OW-1:HW];
		hlx_s3 <= ux_s2[OW-1:HW] * ux_s2[HW-1:0];
		llx_s3 <= ux_s2[HW-1:0] * ux_s2[HW-1:0];
		hhy_s3 <= uy_s2[OW-1:HW] * uy_s2[OW-1:HW];
		hly_s3 <= uy_s2[OW-1:HW] * uy_s2[HW-1:0];
		lly_s3 <= uy_s2[HW-1:0] * uy_s2[HW-1:0];
		cen_s3 <= cen_s2;
	end

	// stage 4: assemble squares
	always_ff @(posedge clk) begin
		sqx_s4 <= {hhx_s3, {OW{1'b0}}} + ((2*OW)'(hlx_s3) << (HW + 1)) + (2*OW)'(llx_s3);
		sqy_s4 <= {hhy_s3, {OW{1'b0}}} + ((2*OW)'(hly_s3) << (HW + 1)) + (2*OW)'(lly_s3);
		cen_s4 <= cen_s3;
	end

	// stage 5: squared distance, root starts empty
	always_ff @(posedge clk) begin
		dsq_s[0] <= (2*RB)'(sqx_s4) + (2*RB)'(sqy_s4);
		sr_s[0] <= '0;
		cr_s[0] <= cen_s4;
	end

	// one root bit per stage
	for (genvar g = 0; g < RB; g++) begin : g_root
		always_ff @(posedge clk) begin
			sr_s[g+1] <= sq_step(sr_s[g], dsq_s[g][2*(RB-1-g) +: 2]);
			dsq_s[g+1] <= dsq_s[g];
			cr_s[g+1] <= cr_s[g];
		end
	end

	// pick the radius: zero when collinear, saturated on any overflow
	always_comb begin
		if (cr_s[RB].meta.degen) begin
			rad_c = '0;
			ovf_c = 1'b0;
		end else if (cr_s[RB].covf || sr_s[RB].root[RB-1]) begin
			rad_c = '1;
			ovf_c = 1'b1;
		end else begin
			rad_c = sr_s[RB].root[OW-1:0];
			ovf_c = 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		res_q.meta <= cr_s[RB].meta;
		res_q.cxm <= cr_s[RB].cxm;
		res_q.cym <= cr_s[RB].cym;
		res_q.rad <= rad_c;
		res_q.ovf <= ovf_c;
	end

	assign out_valid = v_s[RB+5];
	assign out_data = res_q;

endmodule
`default_nettype wire

// ===== hdl/triangle_circumcircle_core.sv =====
// Triangle circumcircle core: orders the vertices anticlockwise, computes the circumcenter
// in thousandths and the circumradius. From the start edge to done a transaction passes through
// six front-end stages, 61 quotient-bit stages of the divider plus load, round and clamp,
// then 55 stages of squaring and a 49-bit root. One transaction enters per cycle; busy
// stays low. Reset clears all valid bits and drops transactions in flight.
// Depends on tricirc_pkg, tricirc_front, tricirc_div and tricirc_sqrt.
`default_nettype none
module triangle_circumcircle_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire tricirc_pkg::coord_t ax, ay, bx, by, cx, cy,
	output logic done,
	output tricirc_pkg::coord_t second_x, second_y, third_x, third_y,
	output logic swapped,
	output tricirc_pkg::milli_t center_x_milli, center_y_milli,
	output logic [tricirc_pkg::OW-1:0] radius_milli,
	output logic degenerate,
	output logic overflow
);
	logic in_valid;
	logic front_valid, cen_valid;
	tricirc_pkg::front_t front_data;
	tricirc_pkg::cen_t cen_data;
	tricirc_pkg::res_t res;

	// every stage advances each cycle, so a transaction is always taken
	assign busy = 1'b0;
	assign in_valid = start && !busy;

	tricirc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy),
		.out_valid(front_valid),
		.out_data(front_data)
	);

	tricirc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(front_valid),
		.in_data(front_data),
		.out_valid(cen_valid),
		.out_data(cen_data)
	);

	tricirc_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(cen_valid),
		.in_data(cen_data),
		.out_valid(done),
		.out_data(res)
	);

	// unpack the result transaction
	assign second_x = res.meta.second_x;
	assign second_y = res.meta.second_y;
	assign third_x = res.meta.third_x;
	assign third_y = res.meta.third_y;
	assign swapped = res.meta.swapped;
	assign degenerate = res.meta.degen;
	assign center_x_milli = res.cxm;
	assign center_y_milli = res.cym;
	assign radius_milli = res.rad;
	assign overflow = res.ovf;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(tricirc_pkg::LATENCY) done)
		else $error("transaction did not complete after the pipeline depth");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, tricirc_pkg::LATENCY))
		else $error("result strobe without a matching transaction");

	a_ovf_radius: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (radius_milli == '1))
		else $error("overflow without a saturated radius");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (swapped && !overflow && center_x_milli == '0
			&& center_y_milli == '0 && radius_milli == '0))
		else $error("collinear transaction with nonzero result");

endmodule
`default_nettype wire

// ===== verif/triangle_circumcircle_core_tb.sv =====
// Self-checking testbench for triangle_circumcircle_core: directed and random triangles,
// each checked against an exact predictor of the vertex order, the center and the radius.
// Depends on tricirc_pkg and the RTL under hdl/.
`timescale 1ns / 1ps
`default_nettype none
module triangle_circumcircle_core_tb;

	localparam int LIMIT = 400000;

	typedef struct {
		tricirc_pkg::coord_t sx, sy, tx, ty;
		logic swp;
		tricirc_pkg::milli_t cxm, cym;
		logic [47:0] rad;
		logic degen, ovf;
	} circ_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	tricirc_pkg::coord_t ax = '0, ay = '0, bx = '0, by = '0, cx = '0, cy = '0;
	tricirc_pkg::coord_t second_x, second_y, third_x, third_y;
	logic swapped, degenerate, overflow;
	tricirc_pkg::milli_t center_x_milli, center_y_milli;
	logic [47:0] radius_milli;

	circ_t circ_q[$];
	int errors = 0;
	int n_sent = 0, n_seen = 0, n_degen = 0, n_ovf = 0, n_swap = 0;
	int cycles = 0;
	int burst_left = 0;

	triangle_circumcircle_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy),
		.done(done), .second_x(second_x), .second_y(second_y),
		.third_x(third_x), .third_y(third_y), .swapped(swapped),
		.center_x_milli(center_x_milli), .center_y_milli(center_y_milli),
		.radius_milli(radius_milli), .degenerate(degenerate), .overflow(overflow)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// round n/d half away from zero and clamp to signed 48 bits
	function automatic tricirc_pkg::milli_t round_clamp(logic signed [127:0] n,
			logic [127:0] d, inout logic ovf);
		logic neg;
		logic [127:0] mag, q, r, lim;
		neg = n < 0;
		mag = neg ? -n : n;
		q = mag / d;
		r = mag % d;
		if (r >= d - r)
			q = q + 1;
		lim = neg ? (128'd1 << 47) : (128'd1 << 47) - 1;
		if (q > lim) begin
			q = lim;
			ovf = 1'b1;
		end
		return neg ? tricirc_pkg::milli_t'(-q) : tricirc_pkg::milli_t'(q);
	endfunction

	// exact circumcircle of one triangle, vertices ordered anticlockwise from A
	function automatic circ_t circumcircle(tricirc_pkg::coord_t pax, tricirc_pkg::coord_t pay,
			tricirc_pkg::coord_t pbx, tricirc_pkg::coord_t pby,
			tricirc_pkg::coord_t pcx, tricirc_pkg::coord_t pcy);
		circ_t o;
		logic signed [127:0] xa, ya, xb, yb, xc, yc, t, area2, dd, sa, sb, sc, nx, ny, ex, ey;
		logic [127:0] dsq, lo, hi, mid;
		logic ovf;
		xa = pax; ya = pay; xb = pbx; yb = pby; xc = pcx; yc = pcy;
		area2 = (xa*yb + xb*yc + xc*ya) - (xb*ya + xc*yb + xa*yc);
		o.swp = area2 <= 0;
		if (o.swp) begin
			t = xb; xb = xc; xc = t;
			t = yb; yb = yc; yc = t;
		end
		o.sx = tricirc_pkg::coord_t'(xb); o.sy = tricirc_pkg::coord_t'(yb);
		o.tx = tricirc_pkg::coord_t'(xc); o.ty = tricirc_pkg::coord_t'(yc);
		dd = 2 * (xa*(yb - yc) + xb*(yc - ya) + xc*(ya - yb));
		o.degen = dd == 0;
		o.cxm = '0; o.cym = '0; o.rad = '0;
		ovf = 1'b0;
		if (!o.degen) begin
			sa = xa*xa + ya*ya;
			sb = xb*xb + yb*yb;
			sc = xc*xc + yc*yc;
			nx = sa*(yb - yc) + sb*(yc - ya) + sc*(ya - yb);
			ny = sa*(xc - xb) + sb*(xa - xc) + sc*(xb - xa);
			o.cxm = round_clamp(nx * 1000, dd, ovf);
			o.cym = round_clamp(ny * 1000, dd, ovf);
			if (ovf) begin
				o.rad = '1;
			end else begin
				ex = xa*1000 - o.cxm;
				ey = ya*1000 - o.cym;
				dsq = ex*ex + ey*ey;
				lo = 0;
				hi = 128'd1 << 49;
				while (lo < hi) begin
					mid = lo + (hi - lo + 1) / 2;
					if (mid*mid <= dsq)
						lo = mid;
					else
						hi = mid - 1;
				end
				if (lo > 128'hFFFF_FFFF_FFFF) begin
					lo = 128'hFFFF_FFFF_FFFF;
					ovf = 1'b1;
				end
				o.rad = lo[47:0];
			end
		end
		o.ovf = ovf;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("MISMATCH result %0d %s: got %0h expected %0h", n_seen, what, got, want);
	endtask

	// compare each finished transaction with the oldest prediction
	always @(posedge clk) begin
		circ_t e;
		if (arst_n && done) begin
			if (circ_q.size() == 0) begin
				report_mismatch("unexpected result", 64'(cycles), '0);
			end else begin
				e = circ_q.pop_front();
				if (second_x !== e.sx) report_mismatch("second_x", second_x, e.sx);
				if (second_y !== e.sy) report_mismatch("second_y", second_y, e.sy);
				if (third_x !== e.tx) report_mismatch("third_x", third_x, e.tx);
				if (third_y !== e.ty) report_mismatch("third_y", third_y, e.ty);
				if (swapped !== e.swp) report_mismatch("swapped", swapped, e.swp);
				if (center_x_milli !== e.cxm)
					report_mismatch("center_x_milli", center_x_milli, e.cxm);
				if (center_y_milli !== e.cym)
					report_mismatch("center_y_milli", center_y_milli, e.cym);
				if (radius_milli !== e.rad)
					report_mismatch("radius_milli", radius_milli, e.rad);
				if (degenerate !== e.degen) report_mismatch("degenerate", degenerate, e.degen);
				if (overflow !== e.ovf) report_mismatch("overflow", overflow, e.ovf);
			end
			n_seen++;
		end
	end

	// hold off a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// drive one triangle, wait for acceptance, then maybe pause between bursts
	task automatic send_triangle(tricirc_pkg::coord_t pax, tricirc_pkg::coord_t pay,
			tricirc_pkg::coord_t pbx, tricirc_pkg::coord_t pby,
			tricirc_pkg::coord_t pcx, tricirc_pkg::coord_t pcy);
		circ_t e;
		@(negedge clk);
		start = 1'b1;
		ax = pax; ay = pay; bx = pbx; by = pby; cx = pcx; cy = pcy;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		e = circumcircle(pax, pay, pbx, pby, pcx, pcy);
		circ_q.push_back(e);
		n_sent++;
		if (e.degen) n_degen++;
		if (e.ovf) n_ovf++;
		if (e.swp) n_swap++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	function automatic tricirc_pkg::coord_t rnd_coord(int span);
		if (span >= 32768)
			return tricirc_pkg::coord_t'($urandom);
		return tricirc_pkg::coord_t'($urandom_range(0, 2*span) - span);
	endfunction

	task automatic test_extremes();
		tricirc_pkg::coord_t mn, mx;
		mn = tricirc_pkg::coord_t'(-32768);
		mx = tricirc_pkg::coord_t'(32767);
		send_triangle(mn, mn, mx, mn, mn, mx);
		send_triangle(mn, mn, mn, mx, mx, mn);
		send_triangle(mx, mx, mn, mx, mx, mn);
		send_triangle(mn, mx, mx, mx, mn, mn);
		send_triangle(mx, mn, mn, mn, 16'sd0, mx);
		send_triangle(16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1);
		send_triangle(16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0);
		send_triangle(-16'sd1, -16'sd1, 16'sd2, -16'sd1, -16'sd1, 16'sd3);
	endtask

	task automatic test_collinear();
		send_triangle(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_triangle(16'sd5, 16'sd7, 16'sd5, 16'sd7, -16'sd3, 16'sd9);
		send_triangle(16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6);
		send_triangle(tricirc_pkg::coord_t'(-32768), tricirc_pkg::coord_t'(-32768),
			16'sd0, 16'sd0,
			tricirc_pkg::coord_t'(32767), tricirc_pkg::coord_t'(32767));
		send_triangle(tricirc_pkg::coord_t'(32767), 16'sd0,
			tricirc_pkg::coord_t'(-32768), 16'sd0, 16'sd0, 16'sd0);
	endtask

	// nearly collinear points push the center out of range
	task automatic test_saturation();
		send_triangle(tricirc_pkg::coord_t'(-32768), tricirc_pkg::coord_t'(-32768),
			tricirc_pkg::coord_t'(32767), tricirc_pkg::coord_t'(32767),
			tricirc_pkg::coord_t'(32767), tricirc_pkg::coord_t'(32766));
		send_triangle(tricirc_pkg::coord_t'(-32768), tricirc_pkg::coord_t'(-32767),
			tricirc_pkg::coord_t'(32767), tricirc_pkg::coord_t'(32767),
			16'sd0, 16'sd0);
		send_triangle(tricirc_pkg::coord_t'(32767), tricirc_pkg::coord_t'(-32768),
			tricirc_pkg::coord_t'(-32768), tricirc_pkg::coord_t'(32767),
			16'sd1, 16'sd0);
		send_triangle(16'sd0, 16'sd0, tricirc_pkg::coord_t'(32767), 16'sd1,
			tricirc_pkg::coord_t'(-32768), 16'sd0);
		send_triangle(16'sd0, 16'sd0, tricirc_pkg::coord_t'(30000), 16'sd1,
			tricirc_pkg::coord_t'(-30000), 16'sd0);
	endtask

	task automatic test_random(int count);
		int kind, span, k;
		tricirc_pkg::coord_t pax, pay, dx, dy;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9);
			span = ($urandom_range(0, 1) == 1) ? 32768 : (1 << $urandom_range(1, 14));
			pax = rnd_coord(span);
			pay = rnd_coord(span);
			if (kind < 6) begin
				send_triangle(pax, pay, rnd_coord(span), rnd_coord(span),
					rnd_coord(span), rnd_coord(span));
			end else begin
				// build along a line, with or without a small kink
				dx = tricirc_pkg::coord_t'($urandom_range(0, 2000) - 1000);
				dy = tricirc_pkg::coord_t'($urandom_range(0, 2000) - 1000);
				k = $urandom_range(1, 30);
				send_triangle(pax, pay, tricirc_pkg::coord_t'(pax + dx),
					tricirc_pkg::coord_t'(pay + dy),
					tricirc_pkg::coord_t'(pax - k*dx
						+ ((kind == 9) ? 0 : $urandom_range(0, 2) - 1)),
					tricirc_pkg::coord_t'(pay - k*dy
						+ ((kind >= 8) ? 0 : $urandom_range(0, 2) - 1)));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_collinear();
		test_saturation();
		test_random(1430);
		@(negedge clk);
		start = 1'b0;
		wait (circ_q.size() == 0);
		repeat (tricirc_pkg::LATENCY + 20) @(posedge clk);
		$display("Covered %0d triangles: %0d reordered, %0d collinear, %0d saturated.",
			n_sent, n_swap, n_degen, n_ovf);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire
